### rtl/mpsm_pkg.sv
package mpsm_pkg;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_BUILD  = 2'd2;
   localparam logic [1:0] CMD_SCAN   = 2'd3;

   localparam logic [2:0] STS_OK        = 3'd0;
   localparam logic [2:0] STS_FULL      = 3'd1;
   localparam logic [2:0] STS_TOO_LONG  = 3'd2;
   localparam logic [2:0] STS_BAD_SYM   = 3'd3;
   localparam logic [2:0] STS_NOT_BUILT = 3'd4;

   localparam logic [7:0] FIRST_SYMBOL = 8'd97;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] symbol;
      logic       pattern_end;
      logic       text_start;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        match_valid;
      logic [7:0]  pattern_node;
      logic [31:0] match_start;
      logic [5:0]  match_length;
      logic        last;
   } rsp_type;

endpackage

### rtl/mpsm_out_stage.sv
module mpsm_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  mpsm_pkg::rsp_type load_data,
   output logic              free,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mpsm_pkg::rsp_type rsp
);

   logic              valid_ff;
   mpsm_pkg::rsp_type data_ff;

   // The slot can take a new beat when empty or when its beat leaves this cycle.
   assign free      = !valid_ff || !rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp       = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load && free) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
      if (load && free) begin
         data_ff <= load_data;
      end
   end

endmodule

### rtl/multi_pattern_string_matcher.sv
// Channel    Direction  Ports                       Beat contents
// request    in         req_valid, req_stall, req   command, symbol, pattern_end, text_start
// response   out        rsp_valid, rsp_stall, rsp   status, match, node, start, length, last
//
// One request is handled at a time by a sequencer around trie memories with registered
// reads, so every read state is followed by a state that uses the data. An insert that
// makes a node also clears the new node's row. A scan walks child lookups, failure steps
// and suffix-chain nodes; a build visits the root's children and then each queued node,
// with failure walks. A clear sweeps the root row, and after reset the root row is cleared
// with req_stall high. A stalled response holds the sequencer until the beat can be taken.
module multi_pattern_string_matcher #(
   parameter int NODES         = 256,
   parameter int ALPHABET      = 26,
   parameter int MAX_DEPTH     = 32,
   parameter int POSITION_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mpsm_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mpsm_pkg::rsp_type rsp
);

   localparam int NW  = $clog2(NODES);
   localparam int NUW = $clog2(NODES + 1);
   localparam int CW  = $clog2(ALPHABET);
   localparam int AW  = $clog2(NODES * ALPHABET);
   localparam int DW  = $clog2(MAX_DEPTH + 1);
   localparam int PW  = POSITION_BITS;

   typedef enum logic [4:0] {
      ST_CLR, ST_IDLE, ST_INS_RD, ST_INS_CHK, ST_INS_MAKE, ST_INS_END, ST_OUT,
      ST_BR_RD, ST_BR_CHK, ST_B_POP, ST_B_PAR, ST_B_FP, ST_B_CH, ST_B_CHW,
      ST_B_WALK, ST_B_WALKW, ST_B_FW, ST_S_RD, ST_S_RDW, ST_S_FW, ST_S_T,
      ST_S_TW, ST_S_END
   } state_type;

   logic [NW-1:0] child_mem [NODES*ALPHABET];
   logic [NW-1:0] fail_mem  [NODES];
   logic          term_mem  [NODES];
   logic [DW-1:0] depth_mem [NODES];
   logic [NW-1:0] queue_mem [NODES];

   logic [NW-1:0] child_rd, fail_rd, queue_rd;
   logic          term_rd;
   logic [DW-1:0] depth_rd;

   state_type      state_ff, ret_ff;
   logic [CW-1:0]  cnt_ff, sym_ff;
   logic [NW-1:0]  row_ff, cur_ff, scan_ff, p_ff, f_ff, ch_ff, fp_ff, hnode_ff;
   logic [NUW-1:0] nodes_ff, head_ff, tail_ff;
   logic [DW-1:0]  cdep_ff, hdep_ff;
   logic           pend_ff, ierr_ff, built_ff, hit_ff;
   logic [PW-1:0]  pos_ff;
   logic [2:0]     st_ff;

   logic              sym_ok;
   logic [7:0]        sym_off;
   logic [NW-1:0]     node_sel;
   logic [CW-1:0]     c_sel;
   logic [AW-1:0]     child_addr;
   logic              child_we;
   logic [NW-1:0]     child_wd;
   logic [NW-1:0]     fail_raddr, fail_waddr, fail_wd;
   logic              fail_we, queue_we, term_we, term_wd, depth_we;
   logic [NW-1:0]     term_waddr;
   logic              emit, out_free, cnt_last;
   mpsm_pkg::rsp_type emit_data;
   logic [PW-1:0]     start_full;

   assign sym_off  = req.symbol - mpsm_pkg::FIRST_SYMBOL;
   assign sym_ok   = (req.symbol >= mpsm_pkg::FIRST_SYMBOL) && (32'(sym_off) < ALPHABET);
   assign cnt_last = (cnt_ff == CW'(ALPHABET - 1));
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      node_sel = '0;
      c_sel    = cnt_ff;
      unique case (state_ff)
         ST_CLR:                 node_sel = row_ff;
         ST_INS_RD, ST_INS_MAKE: begin
            node_sel = cur_ff;
            c_sel    = sym_ff;
         end
         ST_B_CH:                node_sel = p_ff;
         ST_B_WALK:              node_sel = f_ff;
         ST_S_RD: begin
            node_sel = f_ff;
            c_sel    = sym_ff;
         end
         default:                node_sel = '0;
      endcase
   end

   assign child_addr = AW'(node_sel) * AW'(ALPHABET) + AW'(c_sel);
   assign child_we   = (state_ff == ST_CLR) || (state_ff == ST_INS_MAKE);
   assign child_wd   = (state_ff == ST_INS_MAKE) ? nodes_ff[NW-1:0] : '0;

   assign fail_raddr = (state_ff == ST_B_PAR) ? queue_rd : f_ff;
   assign fail_waddr = (state_ff == ST_BR_CHK) ? child_rd : ch_ff;
   assign fail_wd    = (state_ff == ST_BR_CHK || child_rd == ch_ff) ? '0 : child_rd;
   assign fail_we    = ((state_ff == ST_BR_CHK) && (child_rd != '0))
                    || ((state_ff == ST_B_WALKW) && !((child_rd == '0) && (f_ff != '0)));
   assign queue_we   = fail_we && (tail_ff < NUW'(NODES));

   assign term_we    = (state_ff == ST_INS_MAKE)
                    || ((state_ff == ST_INS_END) && pend_ff && !ierr_ff && (cur_ff != '0));
   assign term_waddr = (state_ff == ST_INS_MAKE) ? nodes_ff[NW-1:0] : cur_ff;
   assign term_wd    = (state_ff == ST_INS_END);
   assign depth_we   = (state_ff == ST_INS_MAKE);

   always_ff @(posedge clock) begin
      child_rd <= child_mem[child_addr];
      if (child_we) begin
         child_mem[child_addr] <= child_wd;
      end
      fail_rd  <= fail_mem[fail_raddr];
      term_rd  <= term_mem[f_ff];
      depth_rd <= depth_mem[f_ff];
      queue_rd <= queue_mem[head_ff[NW-1:0]];
      if (fail_we) begin
         fail_mem[fail_waddr] <= fail_wd;
      end
      if (queue_we) begin
         queue_mem[tail_ff[NW-1:0]] <= fail_waddr;
      end
      if (term_we) begin
         term_mem[term_waddr] <= term_wd;
      end
      if (depth_we) begin
         depth_mem[nodes_ff[NW-1:0]] <= cdep_ff + DW'(1);
      end
   end

   assign start_full = pos_ff - PW'(hdep_ff) + PW'(1);

   always_comb begin
      emit      = 1'b0;
      emit_data = '0;
      emit_data.last = 1'b1;
      unique case (state_ff)
         ST_OUT: begin
            emit             = 1'b1;
            emit_data.status = st_ff;
         end
         ST_S_TW, ST_S_END: begin
            emit = (state_ff == ST_S_END) || (term_rd && hit_ff);
            emit_data.match_valid  = hit_ff;
            emit_data.pattern_node = hit_ff ? 8'(hnode_ff) : 8'd0;
            emit_data.match_start  = hit_ff ? 32'(start_full) : 32'd0;
            emit_data.match_length = hit_ff ? 6'(hdep_ff) : 6'd0;
            emit_data.last         = (state_ff == ST_S_END);
         end
         default: emit = 1'b0;
      endcase
   end

   mpsm_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (emit),
      .load_data (emit_data),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
         ret_ff   <= ST_IDLE;
         cnt_ff   <= '0;
         row_ff   <= '0;
         nodes_ff <= NUW'(1);
         cur_ff   <= '0;
         cdep_ff  <= '0;
         ierr_ff  <= 1'b0;
         built_ff <= 1'b0;
         scan_ff  <= '0;
         pos_ff   <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         hit_ff   <= 1'b0;
         st_ff    <= mpsm_pkg::STS_OK;
      end else begin
         if (queue_we) begin
            tail_ff <= tail_ff + NUW'(1);
         end
         unique case (state_ff)
            ST_CLR: begin
               if (cnt_last) begin
                  cnt_ff   <= '0;
                  state_ff <= ret_ff;
               end else begin
                  cnt_ff <= cnt_ff + CW'(1);
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  sym_ff  <= sym_off[CW-1:0];
                  pend_ff <= req.pattern_end;
                  unique case (req.command)
                     mpsm_pkg::CMD_CLEAR: begin
                        st_ff    <= mpsm_pkg::STS_OK;
                        nodes_ff <= NUW'(1);
                        cur_ff   <= '0;
                        cdep_ff  <= '0;
                        ierr_ff  <= 1'b0;
                        built_ff <= 1'b0;
                        scan_ff  <= '0;
                        pos_ff   <= '0;
                        row_ff   <= '0;
                        cnt_ff   <= '0;
                        ret_ff   <= ST_OUT;
                        state_ff <= ST_CLR;
                     end
                     mpsm_pkg::CMD_INSERT: begin
                        built_ff <= 1'b0;
                        if (ierr_ff) begin
                           st_ff    <= mpsm_pkg::STS_OK;
                           state_ff <= ST_INS_END;
                        end else if (!sym_ok) begin
                           st_ff    <= mpsm_pkg::STS_BAD_SYM;
                           ierr_ff  <= 1'b1;
                           state_ff <= ST_INS_END;
                        end else begin
                           st_ff    <= mpsm_pkg::STS_OK;
                           state_ff <= ST_INS_RD;
                        end
                     end
                     mpsm_pkg::CMD_BUILD: begin
                        st_ff    <= mpsm_pkg::STS_OK;
                        cnt_ff   <= '0;
                        head_ff  <= '0;
                        tail_ff  <= '0;
                        state_ff <= ST_BR_RD;
                     end
                     default: begin
                        hit_ff <= 1'b0;
                        f_ff   <= req.text_start ? '0 : scan_ff;
                        if (built_ff && !sym_ok) begin
                           scan_ff  <= '0;
                           pos_ff   <= (req.text_start ? '0 : pos_ff) + PW'(1);
                           st_ff    <= mpsm_pkg::STS_BAD_SYM;
                           state_ff <= ST_OUT;
                        end else begin
                           if (req.text_start) begin
                              scan_ff <= '0;
                              pos_ff  <= '0;
                           end
                           if (!built_ff) begin
                              st_ff    <= mpsm_pkg::STS_NOT_BUILT;
                              state_ff <= ST_OUT;
                           end else begin
                              state_ff <= ST_S_RD;
                           end
                        end
                     end
                  endcase
               end
            end
            ST_INS_RD: state_ff <= ST_INS_CHK;
            ST_INS_CHK: begin
               if (child_rd != '0) begin
                  cur_ff   <= child_rd;
                  cdep_ff  <= cdep_ff + DW'(1);
                  state_ff <= ST_INS_END;
               end else if (cdep_ff >= DW'(MAX_DEPTH)) begin
                  st_ff    <= mpsm_pkg::STS_TOO_LONG;
                  ierr_ff  <= 1'b1;
                  state_ff <= ST_INS_END;
               end else if (nodes_ff >= NUW'(NODES)) begin
                  st_ff    <= mpsm_pkg::STS_FULL;
                  ierr_ff  <= 1'b1;
                  state_ff <= ST_INS_END;
               end else begin
                  state_ff <= ST_INS_MAKE;
               end
            end
            ST_INS_MAKE: begin
               // The new node's row is swept to zero before it can be read.
               cur_ff   <= nodes_ff[NW-1:0];
               cdep_ff  <= cdep_ff + DW'(1);
               nodes_ff <= nodes_ff + NUW'(1);
               row_ff   <= nodes_ff[NW-1:0];
               cnt_ff   <= '0;
               ret_ff   <= ST_INS_END;
               state_ff <= ST_CLR;
            end
            ST_INS_END: begin
               if (pend_ff) begin
                  cur_ff  <= '0;
                  cdep_ff <= '0;
                  ierr_ff <= 1'b0;
               end
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_BR_RD: state_ff <= ST_BR_CHK;
            ST_BR_CHK: begin
               if (cnt_last) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_B_POP;
               end else begin
                  cnt_ff   <= cnt_ff + CW'(1);
                  state_ff <= ST_BR_RD;
               end
            end
            ST_B_POP: begin
               if (head_ff == tail_ff) begin
                  built_ff <= 1'b1;
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_B_PAR;
               end
            end
            ST_B_PAR: begin
               p_ff     <= queue_rd;
               head_ff  <= head_ff + NUW'(1);
               state_ff <= ST_B_FP;
            end
            ST_B_FP: begin
               fp_ff    <= fail_rd;
               cnt_ff   <= '0;
               state_ff <= ST_B_CH;
            end
            ST_B_CH: state_ff <= ST_B_CHW;
            ST_B_CHW, ST_B_WALKW: begin
               if ((state_ff == ST_B_CHW) && (child_rd != '0)) begin
                  ch_ff    <= child_rd;
                  f_ff     <= fp_ff;
                  state_ff <= ST_B_WALK;
               end else if ((state_ff == ST_B_WALKW) && (child_rd == '0) && (f_ff != '0)) begin
                  state_ff <= ST_B_FW;
               end else if (cnt_last) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_B_POP;
               end else begin
                  cnt_ff   <= cnt_ff + CW'(1);
                  state_ff <= ST_B_CH;
               end
            end
            ST_B_WALK: state_ff <= ST_B_WALKW;
            ST_B_FW: begin
               f_ff     <= fail_rd;
               state_ff <= ST_B_WALK;
            end
            ST_S_RD: state_ff <= ST_S_RDW;
            ST_S_RDW: begin
               if ((child_rd == '0) && (f_ff != '0)) begin
                  state_ff <= ST_S_FW;
               end else begin
                  f_ff     <= child_rd;
                  scan_ff  <= child_rd;
                  state_ff <= ST_S_T;
               end
            end
            ST_S_FW: begin
               f_ff     <= fail_rd;
               state_ff <= ST_S_RD;
            end
            ST_S_T: begin
               state_ff <= (f_ff == '0) ? ST_S_END : ST_S_TW;
            end
            ST_S_TW: begin
               // A match is held back one step so that the last flag is known.
               if (!emit || out_free) begin
                  if (term_rd) begin
                     hit_ff   <= 1'b1;
                     hnode_ff <= f_ff;
                     hdep_ff  <= depth_rd;
                  end
                  f_ff     <= fail_rd;
                  state_ff <= ST_S_T;
               end
            end
            ST_S_END: begin
               if (out_free) begin
                  pos_ff   <= pos_ff + PW'(1);
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

### bench/multi_pattern_string_matcher_checker.sv
module multi_pattern_string_matcher_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  mpsm_pkg::req_type req,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  mpsm_pkg::rsp_type rsp,
   output int                fail_count,
   output int                pending
);

   localparam int NODE_COUNT = 256;
   localparam int LETTERS    = 26;
   localparam int DEPTH_MAX  = 32;

   logic [7:0]  trie_child [NODE_COUNT*LETTERS];
   logic [7:0]  fail_link [NODE_COUNT];
   logic        is_terminal [NODE_COUNT];
   int          node_depth [NODE_COUNT];
   int          used_nodes;
   logic [7:0]  cursor;
   logic        cursor_error;
   logic        built;
   logic [7:0]  scan_at;
   logic [31:0] text_pos;

   mpsm_pkg::rsp_type expected_beats [$];

   task automatic wipe_dictionary();
      for (int i = 0; i < NODE_COUNT*LETTERS; i++) trie_child[i] = '0;
      for (int i = 0; i < NODE_COUNT; i++) begin
         fail_link[i] = '0;
         is_terminal[i] = 1'b0;
         node_depth[i] = 0;
      end
      used_nodes = 1;
      cursor = '0;
      cursor_error = 1'b0;
      built = 1'b0;
      scan_at = '0;
      text_pos = '0;
   endtask

   function automatic logic [7:0] child(logic [7:0] n, int c);
      return trie_child[int'(n)*LETTERS + c];
   endfunction

   function automatic bit letter_index(logic [7:0] s, output int idx);
      idx = int'(s) - int'(mpsm_pkg::FIRST_SYMBOL);
      return s >= mpsm_pkg::FIRST_SYMBOL && idx < LETTERS;
   endfunction

   task automatic add_beat(logic [2:0] st, logic mv, logic [7:0] node,
                           logic [31:0] start, logic [5:0] len);
      mpsm_pkg::rsp_type b;
      b = '{status: st, match_valid: mv, pattern_node: node, match_start: start,
            match_length: len, last: 1'b0};
      expected_beats.push_back(b);
   endtask

   task automatic link_failures();
      int bfs [NODE_COUNT];
      int head, tail, steps;
      logic [7:0] p, ch, f, g;
      head = 0;
      tail = 0;
      fail_link[0] = '0;
      for (int c = 0; c < LETTERS; c++) begin
         ch = child(8'd0, c);
         if (ch != 0 && tail < NODE_COUNT) begin
            fail_link[ch] = '0;
            bfs[tail++] = int'(ch);
         end
      end
      while (head < tail) begin
         p = 8'(bfs[head++]);
         for (int c = 0; c < LETTERS; c++) begin
            ch = child(p, c);
            if (ch == 0) continue;
            f = fail_link[p];
            steps = 0;
            while (child(f, c) == 0 && f != 0 && steps <= DEPTH_MAX) begin
               f = fail_link[f];
               steps++;
            end
            g = child(f, c);
            fail_link[ch] = (g != ch) ? g : 8'd0;
            if (tail < NODE_COUNT) bfs[tail++] = int'(ch);
         end
      end
      built = 1'b1;
   endtask

   task automatic predict_matches(mpsm_pkg::req_type r);
      int c, steps, n, first;
      logic [2:0] st;
      logic [7:0] p, t;
      first = expected_beats.size();
      n = 0;
      st = mpsm_pkg::STS_OK;
      case (r.command)
         mpsm_pkg::CMD_CLEAR: begin
            wipe_dictionary();
            add_beat(mpsm_pkg::STS_OK, 1'b0, 8'd0, 32'd0, 6'd0);
         end
         mpsm_pkg::CMD_INSERT: begin
            built = 1'b0;
            if (!cursor_error) begin
               if (!letter_index(r.symbol, c)) begin
                  st = mpsm_pkg::STS_BAD_SYM;
               end else begin
                  p = child(cursor, c);
                  if (p == 0) begin
                     if (node_depth[cursor] >= DEPTH_MAX) st = mpsm_pkg::STS_TOO_LONG;
                     else if (used_nodes >= NODE_COUNT) st = mpsm_pkg::STS_FULL;
                     else begin
                        p = used_nodes[7:0];
                        used_nodes++;
                        trie_child[int'(cursor)*LETTERS + c] = p;
                        node_depth[p] = node_depth[cursor] + 1;
                        is_terminal[p] = 1'b0;
                        fail_link[p] = '0;
                     end
                  end
                  if (st == mpsm_pkg::STS_OK) cursor = p;
               end
               if (st != mpsm_pkg::STS_OK) cursor_error = 1'b1;
            end
            if (r.pattern_end) begin
               if (!cursor_error && cursor != 0) is_terminal[cursor] = 1'b1;
               cursor = '0;
               cursor_error = 1'b0;
            end
            add_beat(st, 1'b0, 8'd0, 32'd0, 6'd0);
         end
         mpsm_pkg::CMD_BUILD: begin
            link_failures();
            add_beat(mpsm_pkg::STS_OK, 1'b0, 8'd0, 32'd0, 6'd0);
         end
         default: begin
            if (r.text_start) begin
               scan_at = '0;
               text_pos = '0;
            end
            if (!built) begin
               add_beat(mpsm_pkg::STS_NOT_BUILT, 1'b0, 8'd0, 32'd0, 6'd0);
            end else if (!letter_index(r.symbol, c)) begin
               scan_at = '0;
               text_pos = text_pos + 32'd1;
               add_beat(mpsm_pkg::STS_BAD_SYM, 1'b0, 8'd0, 32'd0, 6'd0);
            end else begin
               p = scan_at;
               steps = 0;
               while (child(p, c) == 0 && p != 0 && steps <= DEPTH_MAX) begin
                  p = fail_link[p];
                  steps++;
               end
               p = child(p, c);
               scan_at = p;
               t = p;
               steps = 0;
               while (t != 0 && n < DEPTH_MAX && steps <= DEPTH_MAX) begin
                  if (is_terminal[t]) begin
                     add_beat(mpsm_pkg::STS_OK, 1'b1, t,
                              text_pos - 32'(node_depth[t]) + 32'd1,
                              node_depth[t][5:0]);
                     n++;
                  end
                  t = fail_link[t];
                  steps++;
               end
               text_pos = text_pos + 32'd1;
               if (n == 0) add_beat(mpsm_pkg::STS_OK, 1'b0, 8'd0, 32'd0, 6'd0);
            end
         end
      endcase
      expected_beats[expected_beats.size()-1].last = 1'b1;
      if (expected_beats.size() <= first) fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
      wipe_dictionary();
   end

   always @(posedge clock) begin
      mpsm_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) predict_matches(req);
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result beat %p", rsp);
            end else begin
               want = expected_beats.pop_front();
               if (rsp !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected %p, got %p", want, rsp);
               end
            end
         end
         pending = expected_beats.size();
      end
   end

endmodule

### bench/multi_pattern_string_matcher_test.sv
module multi_pattern_string_matcher_test;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   mpsm_pkg::req_type req = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   mpsm_pkg::rsp_type rsp;
   int                fail_count;
   int                pending;
   bit                quiet_period = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   multi_pattern_string_matcher u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req(req),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
   );

   multi_pattern_string_matcher_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req(req),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
      .fail_count(fail_count), .pending(pending)
   );

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_period || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // The receiver stalls in bursts; quiet stretches keep the bursts and gaps as short as they can be.
   initial begin
      @(negedge reset);
      forever begin
         repeat (idle_length()) @(negedge clock);
         rsp_stall <= 1'b1;
         repeat (idle_length() + 1) @(negedge clock);
         rsp_stall <= 1'b0;
         @(negedge clock);
      end
   end

   task automatic send(logic [1:0] cmd, logic [7:0] sym, logic pend, logic tstart);
      int gap;
      gap = idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req <= '{command: cmd, symbol: sym, pattern_end: pend, text_start: tstart};
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic insert_word(string w);
      for (int i = 0; i < w.len(); i++)
         send(mpsm_pkg::CMD_INSERT, w[i], i == w.len() - 1, 1'b0);
   endtask

   task automatic scan_text(string w, bit restart);
      for (int i = 0; i < w.len(); i++)
         send(mpsm_pkg::CMD_SCAN, w[i], 1'b0, restart && i == 0);
   endtask

   function automatic logic [7:0] pick_symbol(int letters);
      if ($urandom_range(0, 99) < 92)
         return mpsm_pkg::FIRST_SYMBOL + 8'($urandom_range(0, letters - 1));
      return 8'($urandom_range(0, 255));
   endfunction

   initial begin
      int len, letters;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: scan before build, a small dictionary, bad symbols, a too long pattern.
      send(mpsm_pkg::CMD_SCAN, "a", 1'b0, 1'b1);
      insert_word("he");
      insert_word("she");
      insert_word("hers");
      send(mpsm_pkg::CMD_INSERT, 8'd0, 1'b0, 1'b0);
      send(mpsm_pkg::CMD_INSERT, "x", 1'b1, 1'b0);
      send(mpsm_pkg::CMD_BUILD, 8'd255, 1'b1, 1'b1);
      scan_text("ushers", 1'b1);
      send(mpsm_pkg::CMD_SCAN, 8'd255, 1'b1, 1'b0);
      send(mpsm_pkg::CMD_SCAN, "z", 1'b0, 1'b1);
      send(mpsm_pkg::CMD_INSERT, "h", 1'b1, 1'b1);
      send(mpsm_pkg::CMD_SCAN, "h", 1'b0, 1'b0);
      send(mpsm_pkg::CMD_CLEAR, 8'hff, 1'b1, 1'b1);
      for (int i = 0; i < 33; i++) send(mpsm_pkg::CMD_INSERT, "q", i == 32, 1'b0);

      // Random dictionaries over few letters, so that matches overlap heavily.
      for (int round = 0; round < 4; round++) begin
         quiet_period = (round == 3);
         if ($urandom_range(0, 2) != 0)
            send(mpsm_pkg::CMD_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom));
         letters = $urandom_range(2, 4);
         repeat ($urandom_range(2, 5)) begin
            len = $urandom_range(1, 5);
            for (int i = 0; i < len; i++)
               send(mpsm_pkg::CMD_INSERT, pick_symbol(letters), i == len - 1, 1'($urandom));
         end
         send(mpsm_pkg::CMD_BUILD, 8'($urandom), 1'($urandom), 1'($urandom));
         repeat ($urandom_range(8, 14))
            send(mpsm_pkg::CMD_SCAN, pick_symbol(letters), 1'($urandom),
                 $urandom_range(0, 15) == 0);
         if ($urandom_range(0, 3) == 0) begin
            send(mpsm_pkg::CMD_INSERT, pick_symbol(letters), 1'b1, 1'b0);
            send(mpsm_pkg::CMD_SCAN, pick_symbol(letters), 1'b0, 1'b0);
         end
      end
      quiet_period = 1'b0;

      // A fresh dictionary scanned over the whole alphabet.
      send(mpsm_pkg::CMD_CLEAR, 8'd0, 1'b0, 1'b0);
      insert_word("ab");
      insert_word("b");
      send(mpsm_pkg::CMD_BUILD, 8'd0, 1'b0, 1'b0);
      repeat (6)
         send(mpsm_pkg::CMD_SCAN, mpsm_pkg::FIRST_SYMBOL + 8'($urandom_range(0, 25)),
              1'b0, 1'b0);
      req_valid <= 1'b0;

      wait (pending == 0);
      repeat (300) @(posedge clock);
      if (fail_count == 0 && pending == 0) $display("PASS multi_pattern_string_matcher");
      else $display("FAIL multi_pattern_string_matcher");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL multi_pattern_string_matcher");
      $finish;
   end

endmodule
